>>> rtl/tcrf_pkg.sv
// ----------------------------------------------------------------------------
// tcrf_pkg
// Shared types and constants of the trace component register file: window
// decode, component kinds and fixed identification values.
// ----------------------------------------------------------------------------
package tcrf_pkg;

  localparam int unsigned COMP_COUNT     = 7;
  localparam int unsigned WORDS_PER_COMP = 1024;
  localparam int unsigned COMP_W         = $clog2(COMP_COUNT);
  localparam int unsigned WORD_W         = $clog2(WORDS_PER_COMP);
  localparam int unsigned MEM_DEPTH      = COMP_COUNT * WORDS_PER_COMP;
  localparam int unsigned MEM_AW         = COMP_W + WORD_W;

  localparam logic [31:0] COMP_ID      = 32'hB105_900D;
  localparam logic [31:0] LOCK_KEY     = 32'hC5AC_CE55;
  localparam logic [31:0] MACRO_CTRL_RST = 32'h0000_0401;

  localparam logic [11:0] OFF_LAR_WORD  = 12'hFB0;
  localparam logic [11:0] OFF_LSR       = 12'hFB4;
  localparam logic [11:0] OFF_DEVID     = 12'hFC8;
  localparam logic [11:0] OFF_IDBYTE    = 12'hFD0;
  localparam logic [11:0] OFF_R004      = 12'h004;
  localparam logic [11:0] OFF_R00C      = 12'h00C;
  localparam logic [11:0] OFF_R010      = 12'h010;
  localparam logic [11:0] OFF_R1E4      = 12'h1E4;
  localparam logic [11:0] OFF_R304      = 12'h304;
  localparam logic [11:0] OFF_R314      = 12'h314;
  localparam logic [7:0]  OFF_PID_HI    = 8'hFE;
  localparam logic [7:0]  OFF_CID_HI    = 8'hFF;

  typedef enum logic [1:0] {
    KIND_FUNNEL = 2'd0,
    KIND_MACRO  = 2'd1,
    KIND_TMC    = 2'd2,
    KIND_PORT   = 2'd3
  } comp_kind_t;

  typedef struct packed {
    logic              hit;
    logic [COMP_W-1:0] comp;
  } win_dec_t;

  function automatic win_dec_t decode_window(input logic [7:0] page);
    win_dec_t d;
    d.hit  = 1'b1;
    d.comp = '0;
    unique case (page)
      8'h41:   d.comp = COMP_W'(0);
      8'h7C:   d.comp = COMP_W'(1);
      8'h7D:   d.comp = COMP_W'(2);
      8'h83:   d.comp = COMP_W'(3);
      8'h84:   d.comp = COMP_W'(4);
      8'h86:   d.comp = COMP_W'(5);
      8'h87:   d.comp = COMP_W'(6);
      default: d.hit  = 1'b0;
    endcase
    return d;
  endfunction

  function automatic comp_kind_t comp_kind(input logic [COMP_W-1:0] comp);
    comp_kind_t k;
    unique case (comp)
      COMP_W'(0), COMP_W'(3): k = KIND_FUNNEL;
      COMP_W'(1), COMP_W'(2): k = KIND_MACRO;
      COMP_W'(4), COMP_W'(5): k = KIND_TMC;
      default:                k = KIND_PORT;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] periph_id(input comp_kind_t k);
    logic [31:0] p;
    unique case (k)
      KIND_FUNNEL: p = 32'h000B_B908;
      KIND_MACRO:  p = 32'h000B_B956;
      KIND_TMC:    p = 32'h000B_B961;
      default:     p = 32'h000B_B912;
    endcase
    return p;
  endfunction

  function automatic logic [31:0] dev_id(input logic [COMP_W-1:0] comp);
    logic [31:0] v;
    unique case (comp)
      COMP_W'(0), COMP_W'(3): v = 32'h0000_0002;
      COMP_W'(4):             v = 32'h0000_0880;
      COMP_W'(5):             v = 32'h0000_0840;
      default:                v = 32'h0000_0000;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] byte_of(input logic [31:0] w, input logic [1:0] sel);
    logic [31:0] b;
    case (sel)
      2'd0:    b = {24'h0, w[7:0]};
      2'd1:    b = {24'h0, w[15:8]};
      2'd2:    b = {24'h0, w[23:16]};
      default: b = {24'h0, w[31:24]};
    endcase
    return b;
  endfunction

endpackage

>>> rtl/trace_component_register_file_top.sv
// ----------------------------------------------------------------------------
// trace_component_register_file_top
// Register window of seven trace components with identification registers.
// Each accepted beat is registered in the s1 stage, then in the output register that drives out_valid.
// Throughput: one beat per cycle; busy is low outside the clear pass.
// Reset: control cleared, then a pass over every word clears the register store
// (macrocell control words loaded with 0x401) while busy is high.
// The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module trace_component_register_file_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [19:0] in_address,
  input  logic [31:0] in_write_data,
  output logic        out_valid,
  output logic [31:0] out_read_data
);

  localparam int unsigned AW = tcrf_pkg::MEM_AW;
  localparam int unsigned WW = tcrf_pkg::WORD_W;
  localparam int unsigned CW = tcrf_pkg::COMP_W;

  logic [31:0] mem [0:tcrf_pkg::MEM_DEPTH-1];

  logic          clearing_r, clearing_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;

  logic               s1_valid_r;
  logic               s1_write_r;
  logic               s1_hit_r;
  logic [CW-1:0]      s1_comp_r;
  logic [11:0]        s1_off_r;
  logic [31:0]        mem_q_r;
  logic               out_valid_r;
  logic [31:0]        out_data_r;
  logic [31:0]        out_data_nxt;

  tcrf_pkg::win_dec_t   in_dec;
  tcrf_pkg::comp_kind_t in_kind;
  tcrf_pkg::comp_kind_t s1_kind;
  logic [11:0]          in_off;
  logic [WW-1:0]        rd_word;
  logic [31:0]          wr_data;
  logic                 accept;
  logic                 acc_wr;
  logic [31:0]          clr_val;
  logic [31:0]          pid;

  assign busy   = clearing_r;
  assign accept = start && !clearing_r;
  assign in_off = in_address[11:0];
  assign in_dec = tcrf_pkg::decode_window(in_address[19:12]);
  assign in_kind = tcrf_pkg::comp_kind(in_dec.comp);

  // Lock status and macrocell status reads redirect the single read port
  always_comb begin
    rd_word = in_off[11:2];
    if (in_off == tcrf_pkg::OFF_LSR) begin
      rd_word = tcrf_pkg::OFF_LAR_WORD[11:2];
    end else if (in_kind == tcrf_pkg::KIND_MACRO && in_off == tcrf_pkg::OFF_R010) begin
      rd_word = '0;
    end
  end

  always_comb begin
    wr_data = in_write_data;
    if (in_off == tcrf_pkg::OFF_R304 && in_kind != tcrf_pkg::KIND_MACRO) begin
      wr_data[6] = 1'b0;
    end
  end

  assign acc_wr = accept && in_mode && in_dec.hit && (in_off < tcrf_pkg::OFF_DEVID);

  assign clr_val = (clr_cnt_r == AW'(tcrf_pkg::WORDS_PER_COMP) ||
                    clr_cnt_r == AW'(2 * tcrf_pkg::WORDS_PER_COMP)) ?
                   tcrf_pkg::MACRO_CTRL_RST : 32'h0;

  always_comb begin
    clearing_nxt = clearing_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clearing_r) begin
      clr_cnt_nxt = clr_cnt_r + AW'(1);
      if (clr_cnt_r == AW'(tcrf_pkg::MEM_DEPTH - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_cnt_r] <= clr_val;
    end else if (acc_wr) begin
      mem[{in_dec.comp, in_off[11:2]}] <= wr_data;
    end
    if (accept) begin
      mem_q_r <= mem[{in_dec.comp, rd_word}];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clearing_r  <= clearing_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      s1_valid_r  <= accept;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_write_r <= in_mode;
      s1_hit_r   <= in_dec.hit;
      s1_comp_r  <= in_dec.comp;
      s1_off_r   <= in_off;
    end
    if (s1_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign s1_kind = tcrf_pkg::comp_kind(s1_comp_r);
  assign pid     = tcrf_pkg::periph_id(s1_kind);

  always_comb begin
    out_data_nxt = mem_q_r;
    if (s1_write_r || !s1_hit_r) begin
      out_data_nxt = 32'h0;
    end else if (s1_off_r[11:4] == tcrf_pkg::OFF_PID_HI) begin
      out_data_nxt = tcrf_pkg::byte_of(pid, s1_off_r[3:2]);
    end else if (s1_off_r[11:4] == tcrf_pkg::OFF_CID_HI) begin
      out_data_nxt = tcrf_pkg::byte_of(tcrf_pkg::COMP_ID, s1_off_r[3:2]);
    end else if (s1_off_r == tcrf_pkg::OFF_IDBYTE) begin
      out_data_nxt = 32'h4;
    end else if (s1_off_r == tcrf_pkg::OFF_DEVID) begin
      out_data_nxt = tcrf_pkg::dev_id(s1_comp_r);
    end else if (s1_off_r == tcrf_pkg::OFF_LSR) begin
      out_data_nxt = (mem_q_r == tcrf_pkg::LOCK_KEY) ? 32'h1 : 32'h3;
    end else if (s1_kind == tcrf_pkg::KIND_MACRO) begin
      case (s1_off_r)
        tcrf_pkg::OFF_R004: out_data_nxt = 32'h0000_4004;
        tcrf_pkg::OFF_R010: out_data_nxt = mem_q_r[10] ? 32'h2 : 32'h0;
        tcrf_pkg::OFF_R1E4: out_data_nxt = 32'h0000_0250;
        tcrf_pkg::OFF_R304: out_data_nxt = 32'h0;
        tcrf_pkg::OFF_R314: out_data_nxt = 32'h1;
        default:            out_data_nxt = mem_q_r;
      endcase
    end else if (s1_kind == tcrf_pkg::KIND_TMC) begin
      case (s1_off_r)
        tcrf_pkg::OFF_R004: out_data_nxt = 32'h0000_1000;
        tcrf_pkg::OFF_R00C: out_data_nxt = 32'h0000_0014;
        tcrf_pkg::OFF_R010: out_data_nxt = 32'hFFFF_FFFF;
        default:            out_data_nxt = mem_q_r;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the trace component register file. Bus reads and
// writes go in through the start/busy command port; a shadow of the seven
// component register pages predicts each read word. Every strobed result is
// checked against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam bit          MODE_RD     = 1'b0;
  localparam bit          MODE_WR     = 1'b1;
  localparam int          N_RANDOM    = 950;
  localparam int          WD_LIMIT    = 40000;
  localparam int          DRAIN_CYC   = 8;
  localparam int          MAX_REPORTS = 10;
  localparam logic [11:0] PID_AREA_LO = 12'hFE0;
  localparam logic [11:0] PID_AREA_HI = 12'hFEF;
  localparam logic [11:0] CID_AREA_LO = 12'hFF0;
  localparam logic [31:0] IDBYTE_VAL  = 32'h0000_0004;
  localparam logic [31:0] MACRO_R004  = 32'h0000_4004;
  localparam logic [31:0] MACRO_R1E4  = 32'h0000_0250;
  localparam logic [31:0] MACRO_R314  = 32'h0000_0001;
  localparam logic [31:0] TMC_R004    = 32'h0000_1000;
  localparam logic [31:0] TMC_R00C    = 32'h0000_0014;
  localparam logic [31:0] TMC_R010    = 32'hFFFF_FFFF;
  localparam logic [31:0] LSR_OPEN    = 32'h0000_0001;
  localparam logic [31:0] LSR_LOCKED  = 32'h0000_0003;

  typedef struct {
    bit          mode;
    logic [19:0] addr;
    logic [31:0] data;
  } bus_op_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_mode = 1'b0;
  logic [19:0] in_address = '0;
  logic [31:0] in_write_data = '0;
  logic        out_valid;
  logic [31:0] out_read_data;

  bus_op_t     pend_q[$];
  bus_op_t     read_data_q[$];
  logic [31:0] shadow_regs[tcrf_pkg::COMP_COUNT][tcrf_pkg::WORDS_PER_COMP];

  int n_total, n_acc, n_res, n_rd, n_wr, n_unmapped, n_err;
  int idle_left, calm_left, wd_cnt;

  trace_component_register_file_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_mode      (in_mode),
    .in_address   (in_address),
    .in_write_data(in_write_data),
    .out_valid    (out_valid),
    .out_read_data(out_read_data)
  );

  always #2 clk = ~clk;

  function automatic logic [7:0] page_of(int idx);
    case (idx)
      0:       return 8'h41;
      1:       return 8'h7C;
      2:       return 8'h7D;
      3:       return 8'h83;
      4:       return 8'h84;
      5:       return 8'h86;
      default: return 8'h87;
    endcase
  endfunction

  // Decoded kind and fixed identification values of one component
  function automatic tcrf_pkg::comp_kind_t kind_of(int c);
    case (c)
      0, 3:    return tcrf_pkg::KIND_FUNNEL;
      1, 2:    return tcrf_pkg::KIND_MACRO;
      4, 5:    return tcrf_pkg::KIND_TMC;
      default: return tcrf_pkg::KIND_PORT;
    endcase
  endfunction

  function automatic logic [31:0] pid_of(tcrf_pkg::comp_kind_t k);
    case (k)
      tcrf_pkg::KIND_FUNNEL: return 32'h000B_B908;
      tcrf_pkg::KIND_MACRO:  return 32'h000B_B956;
      tcrf_pkg::KIND_TMC:    return 32'h000B_B961;
      default:               return 32'h000B_B912;
    endcase
  endfunction

  function automatic logic [31:0] devid_of(int c);
    case (c)
      0, 3:    return 32'h0000_0002;
      4:       return 32'h0000_0880;
      5:       return 32'h0000_0840;
      default: return 32'h0000_0000;
    endcase
  endfunction

  function automatic void reset_shadow();
    for (int c = 0; c < tcrf_pkg::COMP_COUNT; c++)
      for (int w = 0; w < tcrf_pkg::WORDS_PER_COMP; w++)
        shadow_regs[c][w] = '0;
    shadow_regs[1][0] = tcrf_pkg::MACRO_CTRL_RST;
    shadow_regs[2][0] = tcrf_pkg::MACRO_CTRL_RST;
  endfunction

  // Applies one access to the shadow and returns the word the block must answer
  function automatic logic [31:0] regfile_access(bit mode, logic [19:0] addr,
                                                 logic [31:0] wdata);
    int                   c;
    tcrf_pkg::comp_kind_t k;
    logic [11:0]          off;
    logic [31:0]          d;
    c   = -1;
    off = addr[11:0];
    d   = wdata;
    for (int i = 0; i < tcrf_pkg::COMP_COUNT; i++)
      if (addr[19:12] == page_of(i)) c = i;
    if (c < 0) return '0;
    k = kind_of(c);
    if (mode == MODE_WR) begin
      if (off < tcrf_pkg::OFF_DEVID) begin
        if (off == tcrf_pkg::OFF_R304 && k != tcrf_pkg::KIND_MACRO) d[6] = 1'b0;
        shadow_regs[c][off[11:2]] = d;
      end
      return '0;
    end
    if (off >= PID_AREA_LO && off <= PID_AREA_HI)
      return (pid_of(k) >> (8 * off[3:2])) & 32'hFF;
    if (off >= CID_AREA_LO) return (tcrf_pkg::COMP_ID >> (8 * off[3:2])) & 32'hFF;
    if (off == tcrf_pkg::OFF_IDBYTE) return IDBYTE_VAL;
    if (off == tcrf_pkg::OFF_DEVID) return devid_of(c);
    if (off == tcrf_pkg::OFF_LSR)
      return (shadow_regs[c][tcrf_pkg::OFF_LAR_WORD[11:2]] == tcrf_pkg::LOCK_KEY) ?
             LSR_OPEN : LSR_LOCKED;
    if (k == tcrf_pkg::KIND_MACRO) begin
      case (off)
        tcrf_pkg::OFF_R004: return MACRO_R004;
        tcrf_pkg::OFF_R010: return shadow_regs[c][0][10] ? 32'h2 : 32'h0;
        tcrf_pkg::OFF_R1E4: return MACRO_R1E4;
        tcrf_pkg::OFF_R304: return '0;
        tcrf_pkg::OFF_R314: return MACRO_R314;
        default: ;
      endcase
    end else if (k == tcrf_pkg::KIND_TMC) begin
      case (off)
        tcrf_pkg::OFF_R004: return TMC_R004;
        tcrf_pkg::OFF_R00C: return TMC_R00C;
        tcrf_pkg::OFF_R010: return TMC_R010;
        default: ;
      endcase
    end
    return shadow_regs[c][off[11:2]];
  endfunction

  // Idle cycles before the next beat: mostly none or short, a few long,
  // with occasional stretches of back-to-back beats
  function automatic int next_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_op(bit mode, logic [19:0] addr, logic [31:0] data);
    bus_op_t op;
    op.mode = mode;
    op.addr = addr;
    op.data = data;
    pend_q.push_back(op);
  endtask

  task automatic add_random_op();
    int          r;
    bit          mode;
    logic [11:0] off;
    logic [19:0] addr;
    logic [31:0] data;
    mode = ($urandom_range(0, 99) < 50) ? MODE_WR : MODE_RD;
    r    = $urandom_range(0, 99);
    if (r < 30) begin
      case ($urandom_range(0, 10))
        0:       off = 12'h000;
        1:       off = tcrf_pkg::OFF_R004;
        2:       off = tcrf_pkg::OFF_R00C;
        3:       off = tcrf_pkg::OFF_R010;
        4:       off = tcrf_pkg::OFF_R1E4;
        5:       off = tcrf_pkg::OFF_R304;
        6:       off = tcrf_pkg::OFF_R314;
        7:       off = tcrf_pkg::OFF_LAR_WORD;
        8:       off = tcrf_pkg::OFF_LSR;
        9:       off = tcrf_pkg::OFF_DEVID;
        default: off = tcrf_pkg::OFF_IDBYTE;
      endcase
      if ($urandom_range(0, 4) == 0) off[1:0] = 2'($urandom_range(0, 3));
    end else if (r < 45) begin
      off = tcrf_pkg::OFF_DEVID + 12'($urandom_range(0, 55));
    end else if (r < 65) begin
      off = 12'($urandom_range(0, 63));
    end else if (r < 80) begin
      off = 12'h300 + 12'($urandom_range(0, 31));
    end else begin
      off = 12'($urandom_range(0, 4095));
    end
    if ($urandom_range(0, 99) < 85)
      addr = {page_of($urandom_range(0, tcrf_pkg::COMP_COUNT - 1)), off};
    else addr = 20'($urandom_range(0, 20'hFFFFF));
    r = $urandom_range(0, 99);
    if (addr[11:0] == tcrf_pkg::OFF_LAR_WORD && r < 50) data = tcrf_pkg::LOCK_KEY;
    else if (r < 10) data = '0;
    else if (r < 20) data = '1;
    else data = $urandom;
    add_op(mode, addr, data);
  endtask

  // Driver: one beat per start/!busy edge, predicted at acceptance
  always @(posedge clk) begin : driver
    bus_op_t op;
    bit      fire;
    if (rst_n) begin
      fire = start && !busy;
      if (fire) begin
        op      = '{in_mode, in_address, in_write_data};
        op.data = regfile_access(in_mode, in_address, in_write_data);
        read_data_q.push_back(op);
        n_acc++;
        if (in_mode == MODE_WR) n_wr++;
        else n_rd++;
        if (!(in_address[19:12] inside {8'h41, 8'h7C, 8'h7D, 8'h83, 8'h84, 8'h86, 8'h87}))
          n_unmapped++;
        idle_left = next_gap();
      end
      if (fire || !start) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (pend_q.size() > 0) begin
          op = pend_q.pop_front();
          in_mode       <= op.mode;
          in_address    <= op.addr;
          in_write_data <= op.data;
          start         <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: results cannot be held off, compare on every strobe
  always @(posedge clk) begin : monitor
    bus_op_t want;
    if (rst_n && out_valid === 1'b1) begin
      n_res++;
      if (read_data_q.size() == 0) begin
        n_err++;
        if (n_err <= MAX_REPORTS)
          $display("unexpected result 0x%08h with nothing pending", out_read_data);
      end else begin
        want = read_data_q.pop_front();
        if (out_read_data !== want.data) begin
          n_err++;
          if (n_err <= MAX_REPORTS)
            $display("mismatch: %s addr 0x%05h read_data expected 0x%08h, got 0x%08h",
                     want.mode == MODE_WR ? "wr" : "rd", want.addr, want.data,
                     out_read_data);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((start && !busy && rst_n) || (rst_n && out_valid === 1'b1)) wd_cnt = 0;
    else wd_cnt++;
    if (wd_cnt >= WD_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d of %0d accepted", wd_cnt, n_acc,
               n_total);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    reset_shadow();
    // directed: decode extremes, fixed registers, ID area, lock, flush bit, unaligned
    add_op(MODE_RD, 20'h7C000, 32'h0);
    add_op(MODE_RD, 20'h7C010, 32'hFFFF_FFFF);
    add_op(MODE_WR, 20'h7C000, 32'h0);
    add_op(MODE_RD, 20'h7C010, 32'h0);
    add_op(MODE_WR, 20'h41304, 32'hFFFF_FFFF);
    add_op(MODE_RD, 20'h41304, 32'h0);
    add_op(MODE_WR, 20'h7D304, 32'hFFFF_FFFF);
    add_op(MODE_RD, 20'h7D304, 32'h0);
    add_op(MODE_WR, 20'h84FB0, tcrf_pkg::LOCK_KEY);
    add_op(MODE_RD, 20'h84FB4, 32'h0);
    add_op(MODE_RD, 20'h86FB4, 32'h0);
    add_op(MODE_WR, 20'h87FC8, 32'h1234_5678);
    add_op(MODE_RD, 20'h87FC8, 32'h0);
    add_op(MODE_WR, 20'h41FFC, 32'hFFFF_FFFF);
    add_op(MODE_RD, 20'h41FFC, 32'h0);
    add_op(MODE_RD, 20'h7DFE0, 32'h0);
    add_op(MODE_RD, 20'h86FC8, 32'h0);
    add_op(MODE_RD, 20'h83FD0, 32'h0);
    add_op(MODE_WR, 20'hFFFFF, 32'hFFFF_FFFF);
    add_op(MODE_RD, 20'hFFFFF, 32'h0);
    add_op(MODE_RD, 20'h00000, 32'h0);
    add_op(MODE_WR, 20'h86003, 32'hA5A5_A5A5);
    add_op(MODE_RD, 20'h86001, 32'h0);
    add_op(MODE_RD, 20'h7C1E4, 32'h0);
    add_op(MODE_RD, 20'h8400C, 32'h0);
    for (int i = 0; i < N_RANDOM; i++) add_random_op();
    n_total = pend_q.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    wait (n_acc == n_total);
    wait (read_data_q.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
    n_err += read_data_q.size();

    $display("covered %0d beats: %0d reads, %0d writes, %0d outside the component pages",
             n_acc, n_rd, n_wr, n_unmapped);
    $display("%0d results checked, %0d failures", n_res, n_err);
    if (n_err == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/tcrf_pkg.sv
rtl/trace_component_register_file_top.sv
verif/testbench.sv
